// File: rtl/core/fas_pkg.sv
// Package: opcodes, transaction types and constants for the float32 add/sub/compare unit.
package fas_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_EQ  = 3'd2;
  localparam logic [2:0] OP_LT  = 3'd3;
  localparam logic [2:0] OP_LE  = 3'd4;

  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned GrsBits  = 3;
  localparam int unsigned WorkBits = 27;

  localparam logic [7:0]  EXP_MAX   = 8'hFF;
  localparam logic [30:0] INF_MAG   = 31'h7F800000;
  localparam logic [30:0] QNAN_MAG  = 31'h7FC00000;
  localparam logic [31:0] QUIET_BIT = 32'h00400000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        invalid;
  } rsp_t;

endpackage

// File: rtl/core/fas_addsub.sv
// Single-pass IEEE 754 single-precision adder/subtractor datapath.
module fas_addsub (
  input  logic        sub,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] result
);
  import fas_pkg::*;

  function automatic logic [30:0] finish(input logic [8:0] te, input logic [26:0] tf);
    logic [2:0]  g;
    logic        inc;
    logic [24:0] r;
    logic [8:0]  te2;
    logic [23:0] r2;
    logic [7:0]  e;
    g   = tf[2:0];
    inc = (g > 3'd4) || ((g == 3'd4) && tf[3]);
    r   = {1'b0, tf[26:3]} + {24'd0, inc};
    if (r[24]) begin
      te2 = te + 9'd1;
      r2  = r[24:1];
    end else begin
      te2 = te;
      r2  = r[23:0];
    end
    e = r2[23] ? te2[7:0] : 8'd0;
    if (te2 >= {1'b0, EXP_MAX}) finish = INF_MAG;
    else finish = {e, r2[22:0]};
  endfunction

  logic [30:0] am, bm, x, y;
  logic        nan_a, nan_b, swap, sign, eff_sub;
  logic [7:0]  xe, ye, xe1, ye1, d;
  logic        x_inf, y_inf, far;
  logic [26:0] xw, yw, ya, diff, tf_a, tf_s;
  logic [27:0] sum;
  logic [8:0]  te_a, te_s, te1;
  logic        add_ovf, zero;
  logic [4:0]  lz;

  always_comb begin
    am      = a[30:0];
    bm      = b[30:0];
    nan_a   = am > INF_MAG;
    nan_b   = bm > INF_MAG;
    swap    = sub ? (am < bm) : (am <= bm);
    sign    = swap ? (sub ? ~b[31] : b[31]) : a[31];
    eff_sub = a[31] ^ b[31] ^ sub;
    x       = swap ? bm : am;
    y       = swap ? am : bm;
    xe      = x[30:23];
    ye      = y[30:23];
    x_inf   = xe == EXP_MAX;
    y_inf   = ye == EXP_MAX;
    far     = (xe - ye) > 8'(WorkBits);
    xe1     = (xe == 8'd0) ? 8'd1 : xe;
    ye1     = (ye == 8'd0) ? 8'd1 : ye;
    xw      = {xe != 8'd0, x[22:0], 3'b000};
    yw      = {ye != 8'd0, y[22:0], 3'b000};
    d       = xe1 - ye1;
    if (d >= 8'(WorkBits)) begin
      ya = {26'd0, |yw};
    end else begin
      ya = (yw >> d[4:0]) | {26'd0, |(yw & ~({27{1'b1}} << d[4:0]))};
    end

    sum = {1'b0, xw} + {1'b0, ya};
    if (sum[27]) begin
      te_a = {1'b0, xe1} + 9'd1;
      tf_a = sum[27:1] | {26'd0, sum[0]};
    end else begin
      te_a = {1'b0, xe1};
      tf_a = sum[26:0];
    end
    add_ovf = sum[27] && (te_a >= {1'b0, EXP_MAX});

    zero = ya >= xw;
    diff = xw - ya;
    lz   = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (diff[i]) lz = 5'(26 - i);
    end
    te1 = {1'b0, xe1} - 9'd1;
    if (te1 < {4'd0, lz}) begin
      tf_s = diff << te1[4:0];
      te_s = 9'd1;
    end else begin
      tf_s = diff << lz;
      te_s = {1'b0, xe1} - {4'd0, lz};
    end

    if (nan_a) begin
      result = a | QUIET_BIT;
    end else if (nan_b) begin
      result = b | QUIET_BIT;
    end else if (!eff_sub) begin
      if (x_inf || y_inf || add_ovf) result = {sign, INF_MAG};
      else result = {sign, finish(te_a, tf_a)};
    end else begin
      if (x_inf && y_inf) result = {sign, QNAN_MAG};
      else if (x_inf) result = {sign, INF_MAG};
      else if (far) result = {sign, x};
      else if (zero) result = 32'd0;
      else result = {sign, finish(te_s, tf_s)};
    end
  end

endmodule

// File: rtl/core/fas_cmp.sv
// Single-precision equal, less-than and less-or-equal compare logic.
module fas_cmp (
  input  logic [2:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        flag
);
  import fas_pkg::*;

  logic nan_any, both_zero, lt, le;

  always_comb begin
    nan_any   = (a[30:0] > INF_MAG) || (b[30:0] > INF_MAG);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a[31] != b[31]) begin
      lt = both_zero ? 1'b0 : a[31];
      le = both_zero ? 1'b1 : a[31];
    end else begin
      lt = a[31] ? (b < a) : (a < b);
      le = a[31] ? (b <= a) : (a <= b);
    end
    case (op)
      OP_EQ:   flag = !nan_any && (both_zero || (a == b));
      OP_LT:   flag = !nan_any && lt;
      OP_LE:   flag = !nan_any && le;
      default: flag = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/float32_add_sub_compare.sv
// Top level: registered float32 add/subtract/compare unit with valid/ready channels.
// Each transaction carries an opcode (add, subtract, equal, less than, less or
// equal) and two single-precision bit patterns, and returns one result word plus
// an invalid flag raised when either operand of a defined opcode is a signaling
// NaN. The unit takes a new transaction every cycle while the result side does not
// stall. A transaction waits in the input register while the full add/round or
// compare path settles, and its result is then presented from the result register;
// either register holds its contents while the result side stalls.
module float32_add_sub_compare (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fas_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fas_pkg::rsp_t rsp
);
  import fas_pkg::*;

  logic        s1_valid;
  req_t        s1_req;
  logic        adv;
  logic [31:0] sum_result;
  logic        cmp_flag;
  logic        snan_a, snan_b;
  rsp_t        rsp_next;

  fas_addsub u_addsub (
    .sub    (s1_req.op == OP_SUB),
    .a      (s1_req.a),
    .b      (s1_req.b),
    .result (sum_result)
  );

  fas_cmp u_cmp (
    .op   (s1_req.op),
    .a    (s1_req.a),
    .b    (s1_req.b),
    .flag (cmp_flag)
  );

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || adv;

  always_comb begin
    snan_a = (s1_req.a[30:0] > INF_MAG) && !s1_req.a[22];
    snan_b = (s1_req.b[30:0] > INF_MAG) && !s1_req.b[22];
    case (s1_req.op)
      OP_ADD, OP_SUB: begin
        rsp_next.result  = sum_result;
        rsp_next.invalid = snan_a || snan_b;
      end
      OP_EQ, OP_LT, OP_LE: begin
        rsp_next.result  = {31'd0, cmp_flag};
        rsp_next.invalid = snan_a || snan_b;
      end
      default: begin
        rsp_next.result  = 32'd0;
        rsp_next.invalid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) s1_valid <= req_valid;
      if (adv) rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) s1_req <= req;
    if (adv && s1_valid) rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("input stalled while output side is free");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && adv) |=> !rsp_valid)
    else $error("result appeared without a transaction in the input register");

  a_undefined_op_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && (s1_req.op != OP_ADD) && (s1_req.op != OP_SUB) &&
     (s1_req.op != OP_EQ) && (s1_req.op != OP_LT) && (s1_req.op != OP_LE))
    |=> (rsp.result == 32'd0) && !rsp.invalid)
    else $error("undefined opcode produced a nonzero result");
`endif

endmodule

// File: tb/fas_checker.sv
// Checker: watches both channels, predicts each float32 result and compares it.
module fas_checker
  import fas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp,
  output int unsigned fail_count,
  output int unsigned pending
);

  rsp_t expected_q[$];

  function automatic logic is_nan(logic [31:0] x);
    return x[30:0] > INF_MAG;
  endfunction

  function automatic logic [31:0] sticky_shift(logic [31:0] v, logic [31:0] n);
    logic [31:0] mask;
    if (n == 0) return v;
    if (n >= 32) return {31'd0, v != 0};
    mask = (32'd1 << n) - 1;
    return (v >> n) | {31'd0, (v & mask) != 0};
  endfunction

  function automatic logic [31:0] pack_rounded(logic [31:0] e, logic [31:0] f);
    logic [2:0] grs;
    grs = f[2:0];
    f = f >> 3;
    if ((grs == 3'd4 && f[0]) || grs > 3'd4) f = f + 1;
    if (f >= 32'h0100_0000) begin
      e = e + 1;
      if (e >= EXP_MAX) return {1'b0, INF_MAG};
      f = f >> 1;
    end
    if (e >= EXP_MAX) return {1'b0, INF_MAG};
    if (!f[23]) e = 0;
    return (e << 23) | (f & 32'h007F_FFFF);
  endfunction

  function automatic logic [31:0] sum_mag(logic [31:0] x, logic [31:0] y);
    logic [31:0] xe, ye, xf, yf, e, f;
    xe = x[30:23]; ye = y[30:23];
    xf = {9'd0, x[22:0]}; yf = {9'd0, y[22:0]};
    if (xe == EXP_MAX || ye == EXP_MAX) return {1'b0, INF_MAG};
    if (xe == 0) xe = 1; else xf[23] = 1'b1;
    if (ye == 0) ye = 1; else yf[23] = 1'b1;
    e = (xe > ye) ? xe : ye;
    xf = sticky_shift(xf << 3, e - xe);
    yf = sticky_shift(yf << 3, e - ye);
    f = xf + yf;
    if (f >= (32'd1 << WorkBits)) begin
      e = e + 1;
      if (e >= EXP_MAX) return {1'b0, INF_MAG};
      f = (f >> 1) | (f & 1);
    end
    return pack_rounded(e, f);
  endfunction

  function automatic logic [31:0] diff_mag(logic [31:0] x, logic [31:0] y);
    logic [31:0] xe, ye, xf, yf, e, f, nbits, sh;
    xe = x[30:23]; ye = y[30:23];
    xf = {9'd0, x[22:0]}; yf = {9'd0, y[22:0]};
    if (xe == EXP_MAX || ye == EXP_MAX)
      return (xe == EXP_MAX && ye == EXP_MAX) ? {1'b0, QNAN_MAG} : {1'b0, INF_MAG};
    if (xe - ye > WorkBits) return x;
    if (xe == 0) xe = 1; else xf[23] = 1'b1;
    if (ye == 0) ye = 1; else yf[23] = 1'b1;
    e = xe;
    xf = xf << 3;
    yf = sticky_shift(yf << 3, xe - ye);
    if (yf >= xf) return 0;
    f = xf - yf;
    nbits = 0;
    for (int i = 0; i < 32; i++) if (f[i]) nbits = i + 1;
    sh = (nbits < WorkBits) ? WorkBits - nbits : 0;
    if (e - 1 < sh) begin
      f = f << (e - 1);
      e = 1;
    end else begin
      e = e - sh;
      f = f << sh;
    end
    return pack_rounded(e, f);
  endfunction

  function automatic logic [31:0] float_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] am, bm, r;
    am = {1'b0, a[30:0]}; bm = {1'b0, b[30:0]};
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (a[31] == b[31]) return {a[31], 31'd0} | sum_mag(am, bm);
    r = (am > bm) ? ({a[31], 31'd0} | diff_mag(am, bm)) : ({b[31], 31'd0} | diff_mag(bm, am));
    if (r[30:0] == 0) return 0;
    return r;
  endfunction

  function automatic logic [31:0] float_sub(logic [31:0] a, logic [31:0] b);
    logic [31:0] am, bm;
    am = {1'b0, a[30:0]}; bm = {1'b0, b[30:0]};
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (a == b) return (am[30:0] == INF_MAG) ? {a[31], QNAN_MAG} : 0;
    if (a[31] != b[31]) return {a[31], 31'd0} | sum_mag(am, bm);
    if (am >= bm) return {a[31], 31'd0} | diff_mag(am, bm);
    return {~b[31], 31'd0} | diff_mag(bm, am);
  endfunction

  function automatic logic float_less(logic [31:0] a, logic [31:0] b, logic or_eq);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[31] != b[31]) begin
      if ((a | b) == 32'h8000_0000) return or_eq;
      return a[31];
    end
    if (or_eq) return a[31] ? (b <= a) : (a <= b);
    return a[31] ? (b < a) : (a < b);
  endfunction

  function automatic rsp_t predict_float_op(req_t t);
    rsp_t r;
    r.invalid = (is_nan(t.a) && !t.a[22]) || (is_nan(t.b) && !t.b[22]);
    r.result = 0;
    case (t.op)
      OP_ADD: r.result = float_add(t.a, t.b);
      OP_SUB: r.result = float_sub(t.a, t.b);
      OP_EQ: begin
        if (is_nan(t.a) || is_nan(t.b)) r.result = 0;
        else if (((t.a | t.b) & 32'h7FFF_FFFF) == 0) r.result = 1;
        else r.result = {31'd0, t.a == t.b};
      end
      OP_LT: r.result = {31'd0, float_less(t.a, t.b, 1'b0)};
      OP_LE: r.result = {31'd0, float_less(t.a, t.b, 1'b1)};
      default: begin
        r.result = 0;
        r.invalid = 1'b0;
      end
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    rsp_t        exp_rsp;
    int unsigned errors;
    errors = 0;
    if (!rst) begin
      if (req_valid && req_ready) expected_q.push_back(predict_float_op(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: result=%h", rsp.result);
          errors = errors + 1;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp.result !== exp_rsp.result) begin
            $error("result: expected %h actual %h", exp_rsp.result, rsp.result);
            errors = errors + 1;
          end
          if (rsp.invalid !== exp_rsp.invalid) begin
            $error("invalid: expected %b actual %b", exp_rsp.invalid, rsp.invalid);
            errors = errors + 1;
          end
        end
      end
    end
    if (errors != 0) fail_count <= fail_count + errors;
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives float32 add/sub/compare stimulus and reports the verdict.
module tb_top;
  import fas_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomCount = 1100;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  logic        hold_off;
  logic        stim_done;

  float32_add_sub_compare u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  fas_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:0] = $urandom_range(0, 1) ? INF_MAG : 31'd0;
      3: v[30:23] = 8'hFE;
      default: ;
    endcase
    return v;
  endfunction

  function automatic req_t random_item();
    req_t t;
    t.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    t.a = pick_operand();
    case ($urandom_range(0, 5))
      0: t.b = t.a;
      1: t.b = {~t.a[31], t.a[30:0]};
      2: t.b = {$urandom_range(0, 1) == 1, t.a[30:23] + 8'($urandom_range(0, 2)) - 8'd1,
                23'($urandom)};
      default: t.b = pick_operand();
    endcase
    return t;
  endfunction

  task automatic send(req_t t);
    req <= t;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    req_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    req_t dir_items[$];
    req_t t;
    int burst;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    stim_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    dir_items = '{
      '{OP_ADD, 32'h3F80_0000, 32'h3F80_0000},
      '{OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF},
      '{OP_ADD, 32'h7F80_0000, 32'hFF80_0000},
      '{OP_SUB, 32'hFF80_0000, 32'hFF80_0000},
      '{OP_SUB, 32'h7F80_0000, 32'h7F80_0000},
      '{OP_ADD, 32'h7F80_0001, 32'h7FC0_0001},
      '{OP_SUB, 32'h3F80_0000, 32'hFFA0_0000},
      '{OP_ADD, 32'h3F80_0000, 32'hBF80_0000},
      '{OP_SUB, 32'h0000_0000, 32'h8000_0000},
      '{OP_SUB, 32'h8000_0000, 32'h0000_0000},
      '{OP_SUB, 32'h4049_0FDB, 32'h4049_0FDB},
      '{OP_ADD, 32'h0000_0001, 32'h807F_FFFF},
      '{OP_ADD, 32'h007F_FFFF, 32'h0000_0001},
      '{OP_SUB, 32'h0080_0000, 32'h0000_0001},
      '{OP_ADD, 32'h4B80_0000, 32'h3F00_0000},
      '{OP_EQ,  32'h0000_0000, 32'h8000_0000},
      '{OP_EQ,  32'h7FC0_0000, 32'h7FC0_0000},
      '{OP_LT,  32'h8000_0000, 32'h0000_0000},
      '{OP_LE,  32'h8000_0000, 32'h0000_0000},
      '{OP_LT,  32'hBF80_0000, 32'hC000_0000},
      '{OP_LE,  32'hFF80_0000, 32'h7F80_0000},
      '{OP_LT,  32'h7F80_0001, 32'h3F80_0000},
      '{3'd5,   32'hFFFF_FFFF, 32'h7F80_0001},
      '{3'd7,   32'h0000_0000, 32'hFFFF_FFFF}
    };
    foreach (dir_items[i]) send(dir_items[i]);
    pause_sender();

    for (int n = 0; n < RandomCount; ) begin
      if (n == 300) begin
        req_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < RandomCount; k++, n++) begin
        t = random_item();
        send(t);
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    req_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    hold_off = 1'b1;
    wait (!rst);
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    rsp_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) rsp_ready <= 1'b0;
      else if ((idle_cycles / 97) % 2 == 0 && $urandom_range(0, 3) == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
